>>> rtl/orot_pkg.sv
// shared constants and the arctangent table for the oriented rectangle overlap test
package orot_pkg;

   localparam int CordicSteps   = 16;
   localparam int CordicStages  = 4;
   localparam int StepsPerStage = CordicSteps / CordicStages;
   localparam int CordicW       = 33;
   localparam int AngleW        = 32;

   localparam logic signed [CordicW-1:0] CordicX0 = 33'sd652032874;

   localparam logic [1:0] RegEgoLength   = 2'd0;
   localparam logic [1:0] RegEgoWidth    = 2'd1;
   localparam logic [1:0] RegOtherLength = 2'd2;
   localparam logic [1:0] RegOtherWidth  = 2'd3;

   localparam logic [15:0] ResetEgoLength   = 16'd1152;
   localparam logic [15:0] ResetEgoWidth    = 16'd461;
   localparam logic [15:0] ResetOtherLength = 16'd1152;
   localparam logic [15:0] ResetOtherWidth  = 16'd461;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic signed [AngleW-1:0] atan_lookup(input logic [3:0] idx);
      logic signed [AngleW-1:0] v;
      case (idx)
         4'd0:    v = 32'sd536870912;
         4'd1:    v = 32'sd316933406;
         4'd2:    v = 32'sd167458907;
         4'd3:    v = 32'sd85004756;
         4'd4:    v = 32'sd42667331;
         4'd5:    v = 32'sd21354465;
         4'd6:    v = 32'sd10679838;
         4'd7:    v = 32'sd5340245;
         4'd8:    v = 32'sd2670163;
         4'd9:    v = 32'sd1335087;
         4'd10:   v = 32'sd667544;
         4'd11:   v = 32'sd333772;
         4'd12:   v = 32'sd166886;
         4'd13:   v = 32'sd83443;
         4'd14:   v = 32'sd41722;
         4'd15:   v = 32'sd20861;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/orot_cordic.sv
// pipelined rotation-mode cordic, four iterations per register stage
module orot_cordic (
   input  logic                                    clock,
   input  logic [orot_pkg::CordicStages-1:0]       adv,
   input  logic [15:0]                             heading,
   output logic signed [orot_pkg::CordicW-1:0]     x_out,
   output logic signed [orot_pkg::CordicW-1:0]     y_out,
   output logic [1:0]                              quad_out
);

   logic signed [orot_pkg::CordicW-1:0] x_ff [orot_pkg::CordicStages];
   logic signed [orot_pkg::CordicW-1:0] y_ff [orot_pkg::CordicStages];
   logic signed [orot_pkg::AngleW-1:0]  z_ff [orot_pkg::CordicStages];
   logic [1:0]                          q_ff [orot_pkg::CordicStages];

   logic [15:0]        hsum;
   logic [1:0]         quad;
   logic signed [15:0] resid;

   always_comb begin
      hsum  = heading + 16'h2000;
      quad  = hsum[15:14];
      resid = $signed(heading - {quad, 14'd0});
   end

   genvar g;
   generate
      for (g = 0; g < orot_pkg::CordicStages; g++) begin : g_stage
         logic signed [orot_pkg::CordicW-1:0] x_in, y_in;
         logic signed [orot_pkg::AngleW-1:0]  z_in;
         logic [1:0]                          q_in;

         always_comb begin
            logic signed [orot_pkg::CordicW-1:0] xa, ya, dx, dy;
            logic signed [orot_pkg::AngleW-1:0]  za;
            if (g == 0) begin
               xa   = orot_pkg::CordicX0;
               ya   = '0;
               za   = {resid, 16'd0};
               q_in = quad;
            end else begin
               xa   = x_ff[(g == 0) ? 0 : g-1];
               ya   = y_ff[(g == 0) ? 0 : g-1];
               za   = z_ff[(g == 0) ? 0 : g-1];
               q_in = q_ff[(g == 0) ? 0 : g-1];
            end
            for (int i = 0; i < orot_pkg::StepsPerStage; i++) begin
               dx = ya >>> (g * orot_pkg::StepsPerStage + i);
               dy = xa >>> (g * orot_pkg::StepsPerStage + i);
               if (!za[orot_pkg::AngleW-1]) begin
                  xa = xa - dx;
                  ya = ya + dy;
                  za = za - orot_pkg::atan_lookup(4'(g * orot_pkg::StepsPerStage + i));
               end else begin
                  xa = xa + dx;
                  ya = ya - dy;
                  za = za + orot_pkg::atan_lookup(4'(g * orot_pkg::StepsPerStage + i));
               end
            end
            x_in = xa;
            y_in = ya;
            z_in = za;
         end

         always_ff @(posedge clock) begin
            if (adv[g]) begin
               x_ff[g] <= x_in;
               y_ff[g] <= y_in;
               z_ff[g] <= z_in;
               q_ff[g] <= q_in;
            end
         end
      end
   endgenerate

   assign x_out    = x_ff[orot_pkg::CordicStages-1];
   assign y_out    = y_ff[orot_pkg::CordicStages-1];
   assign quad_out = q_ff[orot_pkg::CordicStages-1];

endmodule

>>> rtl/oriented_rect_overlap_test_top.sv
// top level: config registers, stream handshake and the separating axis pipeline
// One pose item enters per clock while the output is not held back by rsp_tready;
// it passes one input stage, four cordic stages of four iterations each, rounding,
// products, sums, the half-extent multiply, totals and the final compare. Each stage
// holds its item only while the stage after it is full and stalled, so bubbles close
// up and input is taken while a result waits. Touching rectangles report overlap.
// Configuration registers sit at byte addresses 0, 4, 8, 12 and read back their low
// 16 bits as written with zeros above; change them only while no item is in flight.
module oriented_rect_overlap_test_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pos_x[15:0], pos_y[31:16], heading[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // overlap[0], zero fill above
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int NStages = 11;

   logic [15:0] elen_ff, ewid_ff, olen_ff, owid_ff;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         elen_ff <= orot_pkg::ResetEgoLength;
         ewid_ff <= orot_pkg::ResetEgoWidth;
         olen_ff <= orot_pkg::ResetOtherLength;
         owid_ff <= orot_pkg::ResetOtherWidth;
      end else if (wr_en) begin
         case (reg_idx)
            orot_pkg::RegEgoLength:   elen_ff <= csr_pwdata[15:0];
            orot_pkg::RegEgoWidth:    ewid_ff <= csr_pwdata[15:0];
            orot_pkg::RegOtherLength: olen_ff <= csr_pwdata[15:0];
            orot_pkg::RegOtherWidth:  owid_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         orot_pkg::RegEgoLength:   csr_prdata = {16'd0, elen_ff};
         orot_pkg::RegEgoWidth:    csr_prdata = {16'd0, ewid_ff};
         orot_pkg::RegOtherLength: csr_prdata = {16'd0, olen_ff};
         orot_pkg::RegOtherWidth:  csr_prdata = {16'd0, owid_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // valid bits and per-stage advance
   logic [NStages-1:0] vld_ff, vld_in, mv;

   always_comb begin
      mv[NStages-1] = !vld_ff[NStages-1] || rsp_tready;
      for (int k = NStages - 2; k >= 0; k--) begin
         mv[k] = !vld_ff[k] || mv[k+1];
      end
      vld_in[0] = req_tvalid;
      for (int k = 1; k < NStages; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NStages; k++) begin
            if (mv[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   assign req_tready = mv[0] && !reset;
   assign rsp_tvalid = vld_ff[NStages-1];

   // stage 0: input
   logic signed [15:0] px0_ff, py0_ff;
   logic [15:0]        hd0_ff;

   always_ff @(posedge clock) begin
      if (mv[0]) begin
         px0_ff <= $signed(req_tdata[15:0]);
         py0_ff <= $signed(req_tdata[31:16]);
         hd0_ff <= req_tdata[47:32];
      end
   end

   // stages 1..4: cordic
   logic signed [orot_pkg::CordicW-1:0] cx, cy;
   logic [1:0]                          cq;
   logic signed [15:0]                  pxd_ff [orot_pkg::CordicStages];
   logic signed [15:0]                  pyd_ff [orot_pkg::CordicStages];

   orot_cordic u_cordic (
      .clock    (clock),
      .adv      (mv[orot_pkg::CordicStages:1]),
      .heading  (hd0_ff),
      .x_out    (cx),
      .y_out    (cy),
      .quad_out (cq)
   );

   always_ff @(posedge clock) begin
      for (int k = 0; k < orot_pkg::CordicStages; k++) begin
         if (mv[k+1]) begin
            pxd_ff[k] <= (k == 0) ? px0_ff : pxd_ff[(k == 0) ? 0 : k-1];
            pyd_ff[k] <= (k == 0) ? py0_ff : pyd_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // stage 5: round and quadrant rotate
   logic signed [orot_pkg::CordicW-1:0] xr, yr;
   logic signed [18:0] cr, sr, c5_in, s5_in, c5_ff, s5_ff;
   logic signed [15:0] px5_ff, py5_ff;

   always_comb begin
      xr = (cx + 33'sd8192) >>> 14;
      yr = (cy + 33'sd8192) >>> 14;
      cr = xr[18:0];
      sr = yr[18:0];
      case (cq)
         2'd0:    begin c5_in = cr;  s5_in = sr;  end
         2'd1:    begin c5_in = -sr; s5_in = cr;  end
         2'd2:    begin c5_in = -cr; s5_in = -sr; end
         default: begin c5_in = sr;  s5_in = -cr; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mv[5]) begin
         c5_ff  <= c5_in;
         s5_ff  <= s5_in;
         px5_ff <= pxd_ff[orot_pkg::CordicStages-1];
         py5_ff <= pyd_ff[orot_pkg::CordicStages-1];
      end
   end

   // stage 6: products
   logic [17:0] ca, sa;
   logic [33:0] olc_ff, ows_ff, ols_ff, owc_ff, elc_ff, ews_ff, els_ff, ewc_ff;
   logic signed [34:0] pxc_ff, pys_ff, pxs_ff, pyc_ff;
   logic [34:0] cc_ff, ss_ff;
   logic [15:0] pxa6_ff, pya6_ff;

   always_comb begin
      ca = c5_ff[18] ? 18'(-c5_ff) : c5_ff[17:0];
      sa = s5_ff[18] ? 18'(-s5_ff) : s5_ff[17:0];
   end

   always_ff @(posedge clock) begin
      if (mv[6]) begin
         olc_ff  <= olen_ff * ca;
         ows_ff  <= owid_ff * sa;
         ols_ff  <= olen_ff * sa;
         owc_ff  <= owid_ff * ca;
         elc_ff  <= elen_ff * ca;
         ews_ff  <= ewid_ff * sa;
         els_ff  <= elen_ff * sa;
         ewc_ff  <= ewid_ff * ca;
         pxc_ff  <= px5_ff * c5_ff;
         pys_ff  <= py5_ff * s5_ff;
         pxs_ff  <= px5_ff * s5_ff;
         pyc_ff  <= py5_ff * c5_ff;
         cc_ff   <= ca * ca;
         ss_ff   <= sa * sa;
         pxa6_ff <= px5_ff[15] ? 16'(-px5_ff) : px5_ff;
         pya6_ff <= py5_ff[15] ? 16'(-py5_ff) : py5_ff;
      end
   end

   // stage 7: sums
   logic [36:0]        hx7_ff, hy7_ff;
   logic [15:0]        pxa7_ff, pya7_ff;
   logic signed [35:0] c3_7_ff, c4_7_ff;
   logic [34:0]        he3_7_ff, he4_7_ff, n7_ff;

   always_ff @(posedge clock) begin
      if (mv[7]) begin
         hx7_ff   <= {5'd0, elen_ff, 16'd0} + 37'(olc_ff) + 37'(ows_ff);
         hy7_ff   <= {5'd0, ewid_ff, 16'd0} + 37'(ols_ff) + 37'(owc_ff);
         pxa7_ff  <= pxa6_ff;
         pya7_ff  <= pya6_ff;
         c3_7_ff  <= 36'(pxc_ff) + 36'(pys_ff);
         c4_7_ff  <= 36'(pyc_ff) - 36'(pxs_ff);
         he3_7_ff <= 35'(elc_ff) + 35'(ews_ff);
         he4_7_ff <= 35'(els_ff) + 35'(ewc_ff);
         n7_ff    <= cc_ff + ss_ff;
      end
   end

   // stage 8: fixed-axis compare, other half extents on rotated axes
   logic               gxy8_ff;
   logic [32:0]        ohi8_ff, whi8_ff;
   logic [33:0]        olo8_ff, wlo8_ff;
   logic signed [35:0] c3_8_ff, c4_8_ff;
   logic [34:0]        he3_8_ff, he4_8_ff;

   always_ff @(posedge clock) begin
      if (mv[8]) begin
         gxy8_ff  <= ({4'd0, pxa7_ff, 17'd0} > hx7_ff) || ({4'd0, pya7_ff, 17'd0} > hy7_ff);
         ohi8_ff  <= olen_ff * n7_ff[34:18];
         olo8_ff  <= olen_ff * n7_ff[17:0];
         whi8_ff  <= owid_ff * n7_ff[34:18];
         wlo8_ff  <= owid_ff * n7_ff[17:0];
         c3_8_ff  <= c3_7_ff;
         c4_8_ff  <= c4_7_ff;
         he3_8_ff <= he3_7_ff;
         he4_8_ff <= he4_7_ff;
      end
   end

   // stage 9: totals and magnitudes
   logic        gxy9_ff;
   logic [55:0] a3_9_ff, a4_9_ff, t3_9_ff, t4_9_ff;
   logic [35:0] a3, a4;

   always_comb begin
      a3 = c3_8_ff[35] ? 36'(-c3_8_ff) : c3_8_ff;
      a4 = c4_8_ff[35] ? 36'(-c4_8_ff) : c4_8_ff;
   end

   always_ff @(posedge clock) begin
      if (mv[9]) begin
         gxy9_ff <= gxy8_ff;
         a3_9_ff <= {3'd0, a3, 17'd0};
         a4_9_ff <= {3'd0, a4, 17'd0};
         t3_9_ff <= {5'd0, he3_8_ff, 16'd0} + {5'd0, ohi8_ff, 18'd0} + 56'(olo8_ff);
         t4_9_ff <= {5'd0, he4_8_ff, 16'd0} + {5'd0, whi8_ff, 18'd0} + 56'(wlo8_ff);
      end
   end

   // stage 10: result
   logic ovl_ff;

   always_ff @(posedge clock) begin
      if (mv[10]) begin
         ovl_ff <= !(gxy9_ff || (a3_9_ff > t3_9_ff) || (a4_9_ff > t4_9_ff));
      end
   end

   assign rsp_tdata = {7'd0, ovl_ff};

endmodule
